/* design/lpnst_pkg.sv */
`default_nettype none
package lpnst_pkg;

  localparam int unsigned STAMP_OFFSET = 3;

  localparam logic [4:0]  SEI_TYPE_RESET    = 5'd6;
  localparam logic [7:0]  PAYLOAD_RESET     = 8'h05;
  localparam logic [31:0] MAX_LENGTH_RESET  = 32'd1048572;

  localparam logic [1:0] REG_SEI_UNIT_TYPE       = 2'd0;
  localparam logic [1:0] REG_WANTED_PAYLOAD_TYPE = 2'd1;
  localparam logic [1:0] REG_MAX_UNIT_LENGTH     = 2'd2;

  typedef struct packed {
    logic [4:0]  sei_unit_type;
    logic [7:0]  wanted_payload_type;
    logic [31:0] max_unit_length;
  } cfg_t;

  typedef struct packed {
    logic [4:0]  unit_type;
    logic [31:0] unit_length;
    logic        has_timestamp;
    logic [63:0] timestamp;
    logic        oversize;
  } result_t;

endpackage
`default_nettype wire

/* design/length_prefixed_nal_sei_timestamp.sv */
// channel   handshake            payload
// in        in_valid / in_stall  in_data_byte[7:0]
// out       out_valid/ out_stall out_unit_type, out_unit_length, out_has_timestamp,
//                                out_timestamp, out_oversize
// cfg       cfg_we               cfg_index[1:0], cfg_data[31:0]
//
// One byte per clock while in_stall is low; a unit result is registered in the cycle after its last byte.
// The parse registers update in the same cycle a byte is taken, so the rate
// is set by the combinational length compare and byte counter.
// Synchronous active-low reset clears the parser and registers to defaults.
// A two-entry output buffer absorbs one result under out_stall; in_stall
// rises only when both entries are held.
`default_nettype none
module length_prefixed_nal_sei_timestamp #(
  parameter int PREFIX_BYTES = 4,
  parameter int STAMP_BYTES  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       out_unit_type,
  output logic [31:0]      out_unit_length,
  output logic             out_has_timestamp,
  output logic [63:0]      out_timestamp,
  output logic             out_oversize,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  lpnst_pkg::cfg_t    cfg_r;
  lpnst_pkg::result_t res;
  lpnst_pkg::result_t out_data;
  logic               res_valid;
  logic               beat_en;
  logic               buf_full;

  assign in_stall = buf_full;
  assign beat_en  = in_valid && !buf_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sei_unit_type       <= lpnst_pkg::SEI_TYPE_RESET;
      cfg_r.wanted_payload_type <= lpnst_pkg::PAYLOAD_RESET;
      cfg_r.max_unit_length     <= lpnst_pkg::MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpnst_pkg::REG_SEI_UNIT_TYPE:       cfg_r.sei_unit_type       <= cfg_data[4:0];
        lpnst_pkg::REG_WANTED_PAYLOAD_TYPE: cfg_r.wanted_payload_type <= cfg_data[7:0];
        lpnst_pkg::REG_MAX_UNIT_LENGTH:     cfg_r.max_unit_length     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lpnst_parser #(
    .PREFIX_BYTES(PREFIX_BYTES),
    .STAMP_BYTES (STAMP_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .beat_en  (beat_en),
    .data_byte(in_data_byte),
    .cfg      (cfg_r),
    .res_valid(res_valid),
    .res      (res)
  );

  lpnst_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (beat_en && res_valid),
    .push_data(res),
    .full     (buf_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  assign out_unit_type     = out_data.unit_type;
  assign out_unit_length   = out_data.unit_length;
  assign out_has_timestamp = out_data.has_timestamp;
  assign out_timestamp     = out_data.timestamp;
  assign out_oversize      = out_data.oversize;

`ifndef SYNTH
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_oversize_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_oversize) |-> (!out_has_timestamp && out_unit_type == 5'd0))
    else $error("oversize unit reports type or timestamp");

  a_empty_no_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_unit_length == 32'd0) |-> (!out_has_timestamp && !out_oversize))
    else $error("empty unit reports timestamp or oversize");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("buffer not empty after reset");
`endif

endmodule
`default_nettype wire

/* design/lpnst_parser.sv */
`default_nettype none
module lpnst_parser #(
  parameter int PREFIX_BYTES = 4,
  parameter int STAMP_BYTES  = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             beat_en,
  input  wire logic [7:0]       data_byte,
  input  wire lpnst_pkg::cfg_t  cfg,
  output logic                  res_valid,
  output lpnst_pkg::result_t    res
);

  localparam int SIW = (STAMP_BYTES > 1) ? $clog2(STAMP_BYTES) : 1;
  localparam logic [31:0] PREFIX_LAST = 32'(PREFIX_BYTES - 1);
  localparam logic [31:0] STAMP_FIRST = 32'(lpnst_pkg::STAMP_OFFSET);
  localparam logic [31:0] STAMP_END   = 32'(lpnst_pkg::STAMP_OFFSET + STAMP_BYTES);

  logic        in_body_r, in_body_nxt;
  logic [31:0] length_shift_r, length_shift_nxt;
  logic [31:0] byte_count_r, byte_count_nxt;
  logic [4:0]  held_type_r, held_type_nxt;
  logic        payload_match_r, payload_match_nxt;
  logic [63:0] stamp_shift_r, stamp_shift_nxt;
  logic [63:0] last_stamp_r, last_stamp_nxt;
  logic        skip_flag_r, skip_flag_nxt;

  logic [31:0]    stamp_rel;
  logic [SIW-1:0] stamp_lane;
  logic           in_stamp;
  logic           last_byte;
  logic [31:0]    prefix_val;
  logic           has_ts;

  assign stamp_rel  = byte_count_r - STAMP_FIRST;
  assign stamp_lane = stamp_rel[SIW-1:0];
  assign in_stamp   = (byte_count_r >= STAMP_FIRST) && (byte_count_r < STAMP_END);
  assign last_byte  = !(({1'b0, byte_count_r} + 33'd1) < {1'b0, length_shift_r});
  assign prefix_val = {length_shift_r[23:0], data_byte};

  always_comb begin
    in_body_nxt       = in_body_r;
    length_shift_nxt  = length_shift_r;
    byte_count_nxt    = byte_count_r;
    held_type_nxt     = held_type_r;
    payload_match_nxt = payload_match_r;
    stamp_shift_nxt   = stamp_shift_r;
    last_stamp_nxt    = last_stamp_r;
    skip_flag_nxt     = skip_flag_r;
    has_ts            = 1'b0;
    res_valid         = 1'b0;
    res               = '0;

    if (!in_body_r) begin
      length_shift_nxt = prefix_val;
      byte_count_nxt   = byte_count_r + 32'd1;
      if (byte_count_r == PREFIX_LAST) begin
        byte_count_nxt = '0;
        if (prefix_val == '0) begin
          res_valid        = 1'b1;
          res.timestamp    = last_stamp_r;
          length_shift_nxt = '0;
        end else begin
          in_body_nxt   = 1'b1;
          skip_flag_nxt = prefix_val > cfg.max_unit_length;
        end
      end
    end else begin
      if (!skip_flag_r) begin
        if (byte_count_r == 32'd0) begin
          held_type_nxt = data_byte[4:0];
        end else if (byte_count_r == 32'd1) begin
          payload_match_nxt = (held_type_r == cfg.sei_unit_type) &&
                              (data_byte == cfg.wanted_payload_type);
        end else if (in_stamp && payload_match_r) begin
          for (int k = 0; k < STAMP_BYTES; k++) begin
            if (stamp_lane == SIW'(k)) begin
              stamp_shift_nxt[8*k +: 8] = stamp_shift_r[8*k +: 8] | data_byte;
            end
          end
        end
      end

      if (!last_byte) begin
        byte_count_nxt = byte_count_r + 32'd1;
      end else begin
        res_valid       = 1'b1;
        res.unit_length = length_shift_r;
        if (skip_flag_r) begin
          res.oversize  = 1'b1;
          res.timestamp = last_stamp_r;
        end else begin
          has_ts = payload_match_nxt && (length_shift_r >= STAMP_END);
          if (has_ts) begin
            last_stamp_nxt = stamp_shift_nxt;
          end
          res.unit_type     = held_type_nxt;
          res.has_timestamp = has_ts;
          res.timestamp     = last_stamp_nxt;
        end
        in_body_nxt       = 1'b0;
        length_shift_nxt  = '0;
        byte_count_nxt    = '0;
        held_type_nxt     = '0;
        payload_match_nxt = 1'b0;
        stamp_shift_nxt   = '0;
        skip_flag_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_body_r       <= 1'b0;
      length_shift_r  <= '0;
      byte_count_r    <= '0;
      held_type_r     <= '0;
      payload_match_r <= 1'b0;
      stamp_shift_r   <= '0;
      last_stamp_r    <= '0;
      skip_flag_r     <= 1'b0;
    end else if (beat_en) begin
      in_body_r       <= in_body_nxt;
      length_shift_r  <= length_shift_nxt;
      byte_count_r    <= byte_count_nxt;
      held_type_r     <= held_type_nxt;
      payload_match_r <= payload_match_nxt;
      stamp_shift_r   <= stamp_shift_nxt;
      last_stamp_r    <= last_stamp_nxt;
      skip_flag_r     <= skip_flag_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/lpnst_out_buf.sv */
`default_nettype none
module lpnst_out_buf (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire lpnst_pkg::result_t push_data,
  output logic                  full,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output lpnst_pkg::result_t    out_data
);

  logic               out_valid_r;
  logic               skid_valid_r;
  lpnst_pkg::result_t out_r;
  lpnst_pkg::result_t skid_r;
  logic               pop;

  assign pop       = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_r <= push_data;
      end else begin
        skid_r <= push_data;
      end
    end
  end

endmodule
`default_nettype wire
